### rtl/core/obwa_pkg.sv
// shared types and rounding helper for the oriented box to world aabb pipeline
// no dependencies
package obwa_pkg;

  localparam int NumCorners = 8;

  typedef logic signed [31:0] len_t;
  typedef logic signed [15:0] quat_t;
  typedef logic        [30:0] ext_t;
  typedef logic signed [47:0] prod1_t;
  typedef logic signed [35:0] tval_t;
  typedef logic signed [51:0] prod2_t;
  typedef logic signed [40:0] world_t;

  typedef enum logic [1:0] {
    REG_EXT_X = 2'd0,
    REG_EXT_Y = 2'd1,
    REG_EXT_Z = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic              valid;
    len_t  [2:0]       pos;
    quat_t [3:0]       q;
  } item_t;

  typedef struct packed {
    logic              valid;
    len_t  [2:0]       pos;
    quat_t [3:0]       q;
    tval_t [7:0][3:0]  t;
  } tstage_t;

  typedef struct packed {
    logic              valid;
    world_t [7:0][2:0] w;
  } wstage_t;

  // floor((s + 2^13) / 2^14)
  function automatic logic signed [39:0] rnd14(input logic signed [53:0] s);
    logic signed [53:0] y;
    y = s + 54'sd8192;
    return y[53:14];
  endfunction

endpackage

### rtl/core/obwa_rot1.sv
// first half of the quaternion product: t = q * corner, two register stages
// depends on obwa_pkg
module obwa_rot1 (
  input  logic                  clk,
  input  logic                  rst,
  input  obwa_pkg::item_t       in_item,
  input  obwa_pkg::ext_t [2:0]  ext,
  output obwa_pkg::tstage_t     out_stage
);

  obwa_pkg::prod1_t p1 [4][3];
  obwa_pkg::item_t  s1;
  obwa_pkg::tstage_t stage_next;

  function automatic logic signed [53:0] term(input obwa_pkg::prod1_t p, input logic neg);
    logic signed [53:0] e;
    e = 54'(p);
    return neg ? -e : e;
  endfunction

  // quaternion part times half extent, shared by all corners
  always_ff @(posedge clk) begin
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 3; b++) begin
        p1[a][b] <= $signed(in_item.q[a]) * $signed({1'b0, ext[b]});
      end
    end
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1 <= in_item;
    end
  end

  always_comb begin
    logic sx, sy, sz;
    stage_next.valid = s1.valid;
    stage_next.pos   = s1.pos;
    stage_next.q     = s1.q;
    for (int c = 0; c < obwa_pkg::NumCorners; c++) begin
      sx = c[0];
      sy = c[1];
      sz = c[2];
      stage_next.t[c][0] = 36'(obwa_pkg::rnd14(term(p1[0][0], sx) + term(p1[2][2], sz)
                                               - term(p1[3][1], sy)));
      stage_next.t[c][1] = 36'(obwa_pkg::rnd14(term(p1[0][1], sy) + term(p1[3][0], sx)
                                               - term(p1[1][2], sz)));
      stage_next.t[c][2] = 36'(obwa_pkg::rnd14(term(p1[0][2], sz) + term(p1[1][1], sy)
                                               - term(p1[2][0], sx)));
      stage_next.t[c][3] = 36'(obwa_pkg::rnd14(-term(p1[1][0], sx) - term(p1[2][1], sy)
                                               - term(p1[3][2], sz)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_stage.valid <= 1'b0;
    end else begin
      out_stage <= stage_next;
    end
  end

endmodule

### rtl/core/obwa_rot2.sv
// second half of the quaternion product: r = t * conj(q), plus center
// depends on obwa_pkg
module obwa_rot2 (
  input  logic               clk,
  input  logic               rst,
  input  obwa_pkg::tstage_t  in_stage,
  output obwa_pkg::wstage_t  out_stage
);

  obwa_pkg::prod2_t m [8][3][4];
  logic                   s_valid;
  obwa_pkg::len_t [2:0]   s_pos;
  obwa_pkg::wstage_t      stage_next;

  always_ff @(posedge clk) begin
    int b, d;
    for (int c = 0; c < obwa_pkg::NumCorners; c++) begin
      for (int a = 0; a < 3; a++) begin
        b = (a == 2) ? 0 : a + 1;
        d = (a == 0) ? 2 : a - 1;
        m[c][a][0] <= $signed(in_stage.t[c][a]) * $signed(in_stage.q[0]);
        m[c][a][1] <= $signed(in_stage.t[c][3]) * $signed(in_stage.q[a + 1]);
        m[c][a][2] <= $signed(in_stage.t[c][b]) * $signed(in_stage.q[d + 1]);
        m[c][a][3] <= $signed(in_stage.t[c][d]) * $signed(in_stage.q[b + 1]);
      end
    end
    s_pos <= in_stage.pos;
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= in_stage.valid;
    end
  end

  always_comb begin
    logic signed [53:0] acc;
    logic signed [39:0] r;
    stage_next.valid = s_valid;
    for (int c = 0; c < obwa_pkg::NumCorners; c++) begin
      for (int a = 0; a < 3; a++) begin
        acc = 54'(m[c][a][0]) - 54'(m[c][a][1]) - 54'(m[c][a][2]) + 54'(m[c][a][3]);
        r   = obwa_pkg::rnd14(acc);
        stage_next.w[c][a] = 41'(r) + 41'($signed(s_pos[a]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_stage.valid <= 1'b0;
    end else begin
      out_stage <= stage_next;
    end
  end

endmodule

### rtl/core/obwa_reduce.sv
// per-axis min and max over the eight corners, then 32-bit saturation
// depends on obwa_pkg
module obwa_reduce (
  input  logic                   clk,
  input  logic                   rst,
  input  obwa_pkg::wstage_t      in_stage,
  output logic                   out_valid,
  output obwa_pkg::len_t [2:0]   out_low,
  output obwa_pkg::len_t [2:0]   out_high
);

  logic            s_valid;
  obwa_pkg::world_t lo_half [2][3];
  obwa_pkg::world_t hi_half [2][3];

  function automatic obwa_pkg::world_t wmin(input obwa_pkg::world_t x, input obwa_pkg::world_t y);
    return (x < y) ? x : y;
  endfunction

  function automatic obwa_pkg::world_t wmax(input obwa_pkg::world_t x, input obwa_pkg::world_t y);
    return (x > y) ? x : y;
  endfunction

  function automatic obwa_pkg::len_t sat32(input obwa_pkg::world_t x);
    if (x > 41'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (x < -41'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // two-level tree over each half of the corners
  always_ff @(posedge clk) begin
    for (int h = 0; h < 2; h++) begin
      for (int a = 0; a < 3; a++) begin
        lo_half[h][a] <= wmin(wmin(in_stage.w[4*h][a],   in_stage.w[4*h+1][a]),
                              wmin(in_stage.w[4*h+2][a], in_stage.w[4*h+3][a]));
        hi_half[h][a] <= wmax(wmax(in_stage.w[4*h][a],   in_stage.w[4*h+1][a]),
                              wmax(in_stage.w[4*h+2][a], in_stage.w[4*h+3][a]));
      end
    end
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= in_stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      out_low[a]  <= sat32(wmin(lo_half[0][a], lo_half[1][a]));
      out_high[a] <= sat32(wmax(hi_half[0][a], hi_half[1][a]));
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s_valid;
    end
  end

endmodule

### rtl/core/oriented_box_world_aabb.sv
// top level: oriented box to world axis-aligned bounding box
// depends on obwa_pkg, obwa_rot1, obwa_rot2, obwa_reduce
//
// usage
//   a box transfer is taken at each rising edge with start high and busy low;
//   pos_* is the box center (signed q16.16), rot_* the orientation
//   quaternion (signed q2.14, used as given, not normalized)
//   half extents are written through cfg_we / cfg_index / cfg_data while no
//   box is in flight; index 0..2 selects x, y, z, index 3 is ignored
//   done is high for exactly one cycle per box, with low_* / high_* holding the
//   saturated per-axis corner minimum and maximum
// throughput and pipeline
//   one box per cycle outside reset, every stage advances each clock
//   pipeline: quaternion-extent products, first product rounding,
//   second products, second rounding plus center, half-tree min/max,
//   final min/max with saturation into the output registers
// reset
//   rst clears every valid bit and sets the half extents to 1.0;
//   busy is high during reset so no box is taken then
// receiver
//   the receiver cannot stall; a result is presented for one cycle only
module oriented_box_world_aabb (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [15:0] rot_w,
  input  logic signed [15:0] rot_i,
  input  logic signed [15:0] rot_j,
  input  logic signed [15:0] rot_k,
  output logic         done,
  output logic signed [31:0] low_x,
  output logic signed [31:0] low_y,
  output logic signed [31:0] low_z,
  output logic signed [31:0] high_x,
  output logic signed [31:0] high_y,
  output logic signed [31:0] high_z
);

  obwa_pkg::ext_t [2:0]   ext;
  obwa_pkg::item_t        in_item;
  obwa_pkg::tstage_t      t_stage;
  obwa_pkg::wstage_t      w_stage;
  obwa_pkg::len_t [2:0]   res_low;
  obwa_pkg::len_t [2:0]   res_high;

  // only reset blocks a transfer
  assign busy = rst;

  // half extent registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ext[0] <= 31'd65536;
      ext[1] <= 31'd65536;
      ext[2] <= 31'd65536;
    end else if (cfg_we) begin
      case (obwa_pkg::reg_idx_t'(cfg_index))
        obwa_pkg::REG_EXT_X: ext[0] <= cfg_data;
        obwa_pkg::REG_EXT_Y: ext[1] <= cfg_data;
        obwa_pkg::REG_EXT_Z: ext[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // pack the incoming box
  always_comb begin
    in_item.valid  = start && !busy;
    in_item.pos[0] = pos_x;
    in_item.pos[1] = pos_y;
    in_item.pos[2] = pos_z;
    in_item.q[0]   = rot_w;
    in_item.q[1]   = rot_i;
    in_item.q[2]   = rot_j;
    in_item.q[3]   = rot_k;
  end

  obwa_rot1 u_rot1 (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .ext       (ext),
    .out_stage (t_stage)
  );

  obwa_rot2 u_rot2 (
    .clk       (clk),
    .rst       (rst),
    .in_stage  (t_stage),
    .out_stage (w_stage)
  );

  obwa_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_stage  (w_stage),
    .out_valid (done),
    .out_low   (res_low),
    .out_high  (res_high)
  );

  assign low_x  = res_low[0];
  assign low_y  = res_low[1];
  assign low_z  = res_low[2];
  assign high_x = res_high[0];
  assign high_y = res_high[1];
  assign high_z = res_high[2];

`ifndef SYNTHESIS
  // every transfer comes out as a done once it has passed the pipeline registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##6 done)
    else $error("result missing six cycles after transfer");

  // no result without a matching earlier transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 6))
    else $error("result without a matching transfer");

  // box bounds are ordered on every axis
  a_ordered: assert property (@(posedge clk) disable iff (rst)
    done |-> (low_x <= high_x) && (low_y <= high_y) && (low_z <= high_z))
    else $error("low bound above high bound");
`endif

endmodule
